@@ design/rhh_pkg.sv @@
// Package for the Robin Hood hash table: request codes, decoded operations,
// back-end states and shared widths. Used by every module of the block but rhh_ram.
package rhh_pkg;

    // Fixed widths of the data and count words and of the slot distance field.
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int DIST_W   = 8;

    // Default parameter values.
    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VAL_BITS    = 32;
    localparam int DEF_PROBE_LIMIT = 128;

    // Request type codes on the req_type port.
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Decoded operation carried from the front end to the back end.
    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_DELETE,
        OP_NONE
    } op_t;

    // Back-end sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_FIT_RD,
        ST_FIT_CHK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_DEL_RD,
        ST_DEL_CHK,
        ST_RESP
    } state_t;

endpackage

@@ design/rhh_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/rhh_front.sv @@
// Front end of the hash table: accepts request words, decodes the request
// type and holds decoded requests in a two-entry queue. Uses rhh_pkg.
module rhh_front #(
    parameter int CAPACITY = rhh_pkg::DEF_CAPACITY,
    parameter int KW       = rhh_pkg::DEF_KEY_BITS,
    parameter int VW       = rhh_pkg::DEF_VAL_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  req_type,
    input  logic [rhh_pkg::DATA_W-1:0]  key,
    input  logic [rhh_pkg::DATA_W-1:0]  write_value,
    input  logic [rhh_pkg::DATA_W-1:0]  hash_value,
    output logic                        q_valid,
    input  logic                        q_ready,
    output rhh_pkg::op_t                q_op,
    output logic [KW-1:0]               q_key,
    output logic [VW-1:0]               q_val,
    output logic [$clog2(CAPACITY)-1:0] q_home
);
    import rhh_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    op_t               op_mem  [2];
    logic [KW-1:0]     key_mem [2];
    logic [VW-1:0]     val_mem [2];
    logic [ADDR_W-1:0] home_mem[2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        fill_reg, fill_next;
    logic              push, pop;
    op_t               dec_op;

    // Decode the request type into an operation.
    always_comb
    begin
        unique case (req_type)
            REQ_LOOKUP: dec_op = OP_LOOKUP;
            REQ_INSERT: dec_op = OP_INSERT;
            REQ_DELETE: dec_op = OP_DELETE;
            REQ_UNUSED: dec_op = OP_NONE;
        endcase
    end

    assign req_ready = (fill_reg != 2'd2);
    assign push      = req_valid && req_ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign pop       = q_valid && q_ready;

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage; the home slot is the low bits of the hash.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]   <= dec_op;
            key_mem[wr_ptr_reg]  <= key[KW-1:0];
            val_mem[wr_ptr_reg]  <= write_value[VW-1:0];
            home_mem[wr_ptr_reg] <= hash_value[ADDR_W-1:0];
        end
    end

    assign q_op   = op_mem[rd_ptr_reg];
    assign q_key  = key_mem[rd_ptr_reg];
    assign q_val  = val_mem[rd_ptr_reg];
    assign q_home = home_mem[rd_ptr_reg];

endmodule

@@ design/rhh_back.sv @@
// Back end of the hash table: sequencer that probes, inserts and removes
// entries in the slot RAM and registers the response word. Uses rhh_pkg
// and rhh_ram.
module rhh_back #(
    parameter int CAPACITY    = rhh_pkg::DEF_CAPACITY,
    parameter int KW          = rhh_pkg::DEF_KEY_BITS,
    parameter int VW          = rhh_pkg::DEF_VAL_BITS,
    parameter int PROBE_LIMIT = rhh_pkg::DEF_PROBE_LIMIT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  rhh_pkg::op_t                 q_op,
    input  logic [KW-1:0]                q_key,
    input  logic [VW-1:0]                q_val,
    input  logic [$clog2(CAPACITY)-1:0]  q_home,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic                         key_was_present,
    output logic [rhh_pkg::DATA_W-1:0]   read_value,
    output logic                         status,
    output logic [rhh_pkg::COUNT_W-1:0]  entry_count
);
    import rhh_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = DIST_W + KW + VW;
    localparam logic [CNT_W+1:0]  FULL_MARK = (CNT_W + 2)'(3 * CAPACITY);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(CAPACITY - 1);
    localparam logic [DIST_W-1:0] LIMIT     = DIST_W'(PROBE_LIMIT);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next, idx_inc, home_reg, home_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [CNT_W-1:0]    step_reg, step_next, cnt_reg, cnt_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [VW-1:0]       val_reg, val_next, rd_reg, rd_next;
    logic                present_reg, present_next, full_reg, full_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                rsp_present_reg, rsp_present_next;
    logic                rsp_status_reg, rsp_status_next;
    logic [VW-1:0]       rsp_rd_reg, rsp_rd_next;
    logic [CNT_W-1:0]    rsp_cnt_reg, rsp_cnt_next;

    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [WORD_W-1:0]   wdata, rdata;
    logic [DIST_W-1:0]   s_dist, s_min;
    logic [KW-1:0]       s_key;
    logic [VW-1:0]       s_val;
    logic                find_hit, find_miss;
    logic [DIST_W:0]     fit_carry;

    rhh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Fields of the slot word read in the previous cycle.
    assign s_dist = rdata[WORD_W-1 -: DIST_W];
    assign s_key  = rdata[VW +: KW];
    assign s_val  = rdata[0 +: VW];

    assign idx_inc   = (idx_reg == LAST_SLOT) ? '0 : idx_reg + ADDR_W'(1);
    assign find_hit  = (s_dist != '0) && (s_dist >= dist_reg) && (s_key == key_reg);
    assign find_miss = (s_dist == '0) || (s_dist < dist_reg)
                       || (!find_hit && dist_reg == LIMIT);
    assign s_min     = (s_dist < dist_reg) ? s_dist : dist_reg;
    assign fit_carry = {1'b0, s_min} + (DIST_W + 1)'(1);

    // Sequencer: next state, RAM accesses and response.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        idx_next         = idx_reg;
        home_next        = home_reg;
        dist_next        = dist_reg;
        step_next        = step_reg;
        cnt_next         = cnt_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        rd_next          = rd_reg;
        present_next     = present_reg;
        full_next        = full_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_present_next = rsp_present_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_rd_next      = rsp_rd_reg;
        rsp_cnt_next     = rsp_cnt_reg;
        q_ready          = 1'b0;
        we               = 1'b0;
        waddr            = idx_reg;
        wdata            = '0;
        raddr            = idx_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                idx_next = idx_inc;
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    op_next      = q_op;
                    key_next     = q_key;
                    val_next     = q_val;
                    home_next    = q_home;
                    idx_next     = q_home;
                    dist_next    = DIST_W'(1);
                    rd_next      = '0;
                    present_next = 1'b0;
                    full_next    = 1'b0;
                    state_next   = (q_op == OP_NONE) ? ST_RESP : ST_FIND_RD;
                end
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND_CHK;
            end
            ST_FIND_CHK:
            begin
                if (find_hit)
                begin
                    present_next = 1'b1;
                    state_next   = ST_RESP;
                    if (op_reg == OP_LOOKUP)
                    begin
                        rd_next = s_val;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        we    = 1'b1;
                        wdata = {s_dist, s_key, val_reg};
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = ST_DEL_RD;
                    end
                end
                else if (find_miss)
                begin
                    state_next = ST_RESP;
                    if (op_reg == OP_INSERT)
                    begin
                        if ({cnt_reg, 2'b00} >= FULL_MARK)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = home_reg;
                            dist_next  = DIST_W'(1);
                            step_next  = '0;
                            state_next = ST_FIT_RD;
                        end
                    end
                end
                else
                begin
                    dist_next  = dist_reg + DIST_W'(1);
                    idx_next   = idx_inc;
                    state_next = ST_FIND_RD;
                end
            end
            ST_FIT_RD:
            begin
                state_next = ST_FIT_CHK;
            end
            ST_FIT_CHK:
            begin
                // Dry run of the insert to check that no entry passes the limit.
                if (s_dist == '0)
                begin
                    idx_next   = home_reg;
                    dist_next  = DIST_W'(1);
                    state_next = ST_INS_RD;
                end
                else if (fit_carry > (DIST_W + 1)'(PROBE_LIMIT) || step_reg == LAST_STEP)
                begin
                    full_next  = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    dist_next  = fit_carry[DIST_W-1:0];
                    step_next  = step_reg + CNT_W'(1);
                    idx_next   = idx_inc;
                    state_next = ST_FIT_RD;
                end
            end
            ST_INS_RD:
            begin
                state_next = ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                idx_next   = idx_inc;
                dist_next  = dist_reg + DIST_W'(1);
                state_next = ST_INS_RD;
                if (s_dist == '0)
                begin
                    we         = 1'b1;
                    wdata      = {dist_reg, key_reg, val_reg};
                    cnt_next   = cnt_reg + CNT_W'(1);
                    idx_next   = idx_reg;
                    state_next = ST_RESP;
                end
                else if (s_dist < dist_reg)
                begin
                    // Swap with the richer resident and carry it onward.
                    we        = 1'b1;
                    wdata     = {dist_reg, key_reg, val_reg};
                    key_next  = s_key;
                    val_next  = s_val;
                    dist_next = s_dist + DIST_W'(1);
                end
            end
            ST_DEL_RD:
            begin
                raddr      = idx_inc;
                state_next = ST_DEL_CHK;
            end
            ST_DEL_CHK:
            begin
                // Pull the following entry back into the hole, or close it.
                we = 1'b1;
                if (s_dist <= DIST_W'(1))
                begin
                    wdata      = '0;
                    state_next = ST_RESP;
                end
                else
                begin
                    wdata      = {s_dist - DIST_W'(1), s_key, s_val};
                    idx_next   = idx_inc;
                    state_next = ST_DEL_RD;
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_present_next = present_reg;
                    rsp_status_next  = full_reg;
                    rsp_rd_next      = rd_reg;
                    rsp_cnt_next     = cnt_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        home_reg        <= home_next;
        dist_reg        <= dist_next;
        step_reg        <= step_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        rd_reg          <= rd_next;
        present_reg     <= present_next;
        full_reg        <= full_next;
        rsp_present_reg <= rsp_present_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_rd_reg      <= rsp_rd_next;
        rsp_cnt_reg     <= rsp_cnt_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign key_was_present = rsp_present_reg;
    assign status          = rsp_status_reg;
    assign read_value      = DATA_W'(rsp_rd_reg);
    assign entry_count     = COUNT_W'(rsp_cnt_reg);

endmodule

@@ design/robin_hood_hash_table.sv @@
// Robin Hood hash table with backward-shift deletion. Requests enter a
// two-word queue and are served one at a time by a sequencer on a single
// slot RAM (one read and one write per cycle); each slot probe is a read
// state followed by a check state. A new-key insert walks the run up to the
// first empty slot twice (one pass checks the probe limit, one places the
// entry), and a delete hit shifts each following entry of the run back.
// While a response word waits for rsp_ready the sequencer holds the next one.
// After reset the sequencer clears the slot distances before serving the
// first request; requests are queued meanwhile.
// The home slot is the low log2(CAPACITY) bits of hash_value, so CAPACITY
// must be a power of two; the block itself does not enforce it.
module robin_hood_hash_table
    import rhh_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_BITS    = DEF_KEY_BITS,
    parameter int VAL_BITS    = DEF_VAL_BITS,
    parameter int PROBE_LIMIT = DEF_PROBE_LIMIT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_type,
    input  logic [DATA_W-1:0]  key,
    input  logic [DATA_W-1:0]  write_value,
    input  logic [DATA_W-1:0]  hash_value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic               key_was_present,
    output logic [DATA_W-1:0]  read_value,
    output logic               status,
    output logic [COUNT_W-1:0] entry_count
);

    localparam int KW     = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
    localparam int VW     = (VAL_BITS < DATA_W) ? VAL_BITS : DATA_W;
    localparam int ADDR_W = $clog2(CAPACITY);

    logic              q_valid, q_ready;
    op_t               q_op;
    logic [KW-1:0]     q_key;
    logic [VW-1:0]     q_val;
    logic [ADDR_W-1:0] q_home;

    rhh_front #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .VW       (VW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .key         (key),
        .write_value (write_value),
        .hash_value  (hash_value),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_op        (q_op),
        .q_key       (q_key),
        .q_val       (q_val),
        .q_home      (q_home)
    );

    rhh_back #(
        .CAPACITY    (CAPACITY),
        .KW          (KW),
        .VW          (VW),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_op            (q_op),
        .q_key           (q_key),
        .q_val           (q_val),
        .q_home          (q_home),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .key_was_present (key_was_present),
        .read_value      (read_value),
        .status          (status),
        .entry_count     (entry_count)
    );

endmodule

@@ design/rhh_checker.sv @@
// Port-level checks for the Robin Hood hash table, bound to the top level.
// Uses rhh_pkg.
module rhh_checker
    import rhh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               key_was_present,
    input logic [DATA_W-1:0]  read_value,
    input logic               status,
    input logic [COUNT_W-1:0] entry_count
);

    localparam logic [COUNT_W+2:0] COUNT_MAX = (COUNT_W + 3)'(3 * CAPACITY + 3);

    // A pending response word holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_count))
        else $error("response word dropped or changed while stalled");

    // A refused insert never reports a present key.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !key_was_present)
        else $error("full status together with key present");

    // A nonzero read value only comes with a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_value != '0 |-> key_was_present && !status)
        else $error("read value without a hit");

    // The table never fills past three quarters.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> {entry_count, 2'b00} <= COUNT_MAX)
        else $error("entry count above the load limit");

endmodule

bind robin_hood_hash_table rhh_checker #(.CAPACITY(CAPACITY)) u_rhh_checker (.*);

@@ bench/robin_hood_hash_table_tb.sv @@
// Testbench for the Robin Hood hash table: drives lookup, insert and delete
// words, predicts every response with a behavioral table, and checks them.
// Depends on rhh_pkg and robin_hood_hash_table.
module robin_hood_hash_table_tb;
    import rhh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP   = DEF_CAPACITY;
    localparam int PLIM  = DEF_PROBE_LIMIT;
    localparam int HMASK = CAP - 1;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] wval;
        logic [DATA_W-1:0] hash;
    } request_t;

    typedef struct packed {
        logic               present;
        logic [DATA_W-1:0]  rval;
        logic               full;
        logic [COUNT_W-1:0] count;
    } response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [1:0] req_type = REQ_LOOKUP;
    logic [DATA_W-1:0] key = '0;
    logic [DATA_W-1:0] write_value = '0;
    logic [DATA_W-1:0] hash_value = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    logic key_was_present;
    logic [DATA_W-1:0] read_value;
    logic status;
    logic [COUNT_W-1:0] entry_count;

    robin_hood_hash_table u_dut (.*);

    always #6 clk = ~clk;

    // Shadow copy of the table used for prediction.
    logic [DIST_W-1:0] tbl_dist [CAP];
    logic [DATA_W-1:0] tbl_key  [CAP];
    logic [DATA_W-1:0] tbl_val  [CAP];
    int unsigned tbl_count;

    request_t  pending_words[$];
    response_t expected_rsp[$];
    logic [DATA_W-1:0] live_keys[$];
    int errors;
    int accepted_reqs, checked_rsps, hits, refusals;
    bit stim_done;
    int idle_cycles;

    function automatic int next_idx(int i);
        return (i + 1) & HMASK;
    endfunction

    function automatic int probe_for(logic [DATA_W-1:0] k, int home);
        int i;
        i = home;
        for (int p = 1; p <= PLIM; p++)
        begin
            if (tbl_dist[i] == 0 || tbl_dist[i] < p)
                return -1;
            if (tbl_key[i] == k)
                return i;
            i = next_idx(i);
        end
        return -1;
    endfunction

    function automatic bit placement_fits(int home);
        int i, carry;
        i = home;
        carry = 1;
        for (int n = 0; n < CAP; n++)
        begin
            if (tbl_dist[i] == 0)
                return 1'b1;
            if (tbl_dist[i] < carry)
                carry = tbl_dist[i];
            i = next_idx(i);
            carry++;
            if (carry > PLIM)
                return 1'b0;
        end
        return 1'b0;
    endfunction

    task automatic place_entry(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v, int home);
        int i, carry, d;
        logic [DATA_W-1:0] tk, tv;
        i = home;
        carry = 1;
        for (int n = 0; n < CAP; n++)
        begin
            d = tbl_dist[i];
            if (d == 0)
            begin
                tbl_dist[i] = DIST_W'(carry);
                tbl_key[i] = k;
                tbl_val[i] = v;
                tbl_count++;
                return;
            end
            if (d < carry)
            begin
                tk = tbl_key[i];
                tv = tbl_val[i];
                tbl_dist[i] = DIST_W'(carry);
                tbl_key[i] = k;
                tbl_val[i] = v;
                k = tk;
                v = tv;
                carry = d;
            end
            i = next_idx(i);
            carry++;
        end
    endtask

    task automatic shift_out(int i);
        int j;
        tbl_count--;
        for (int n = 0; n < CAP; n++)
        begin
            j = next_idx(i);
            if (tbl_dist[j] <= 1)
                break;
            tbl_dist[i] = DIST_W'(tbl_dist[j] - 1);
            tbl_key[i] = tbl_key[j];
            tbl_val[i] = tbl_val[j];
            i = j;
        end
        tbl_dist[i] = 0;
    endtask

    // Applies one request to the shadow table and returns the response.
    task automatic apply_request(request_t r, output response_t rsp);
        int home, at;
        home = r.hash & HMASK;
        rsp = '0;
        at = (r.kind == REQ_UNUSED) ? -1 : probe_for(r.key, home);
        case (r.kind)
            REQ_LOOKUP:
                if (at >= 0)
                begin
                    rsp.present = 1'b1;
                    rsp.rval = tbl_val[at];
                end
            REQ_INSERT:
                if (at >= 0)
                begin
                    rsp.present = 1'b1;
                    tbl_val[at] = r.wval;
                end
                else if (tbl_count * 4 >= CAP * 3 || !placement_fits(home))
                    rsp.full = 1'b1;
                else
                    place_entry(r.key, r.wval, home);
            REQ_DELETE:
                if (at >= 0)
                begin
                    rsp.present = 1'b1;
                    shift_out(at);
                end
            default: ;
        endcase
        rsp.count = COUNT_W'(tbl_count);
    endtask

    function automatic request_t make_req(logic [1:0] t, logic [DATA_W-1:0] k,
                                          logic [DATA_W-1:0] v, logic [DATA_W-1:0] h);
        request_t r;
        r.kind = t;
        r.key = k;
        r.wval = v;
        r.hash = h;
        return r;
    endfunction

    // Keys share a pool of up to 900 so lookups and deletes hit; with crowd set, hashes crowd 64 homes.
    function automatic request_t random_req(int crowd);
        logic [DATA_W-1:0] k, h;
        int sel;
        if (live_keys.size() > 0 && $urandom_range(99) < 60)
            k = live_keys[$urandom_range(live_keys.size() - 1)];
        else
        begin
            k = $urandom();
            live_keys.push_back(k);
            if (live_keys.size() > 900)
                live_keys.delete(0);
        end
        // The hash is a function of the key so repeats find the same home.
        h = {k[15:0] ^ k[31:16], k[31:16]} * 32'h9E37_79B1;
        if (crowd != 0)
            h[9:0] = h[9:0] & 10'h03F;
        sel = $urandom_range(99);
        return make_req(sel < 45 ? REQ_INSERT : sel < 75 ? REQ_LOOKUP :
                        sel < 97 ? REQ_DELETE : REQ_UNUSED, k, $urandom(), h);
    endfunction

    // Driver: bursts of words with random gaps between them.
    int gap_left, burst_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                accepted_reqs++;
            if (!req_valid || req_ready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 15);
                end
                if (gap_left > 0 || pending_words.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    req_valid <= 1'b0;
                end
                else
                begin
                    request_t r;
                    response_t e;
                    r = pending_words.pop_front();
                    apply_request(r, e);
                    expected_rsp.push_back(e);
                    req_valid <= 1'b1;
                    req_type <= r.kind;
                    key <= r.key;
                    write_value <= r.wval;
                    hash_value <= r.hash;
                    burst_left--;
                end
            end
        end
    end

    // Monitor and checker; the response side stalls on its own pattern.
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_phase = 0;
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (req_valid && req_ready)
                idle_cycles = 0;
            if (rsp_valid && rsp_ready)
            begin
                response_t e;
                idle_cycles = 0;
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected response word");
                    errors++;
                end
                else
                begin
                    e = expected_rsp.pop_front();
                    checked_rsps++;
                    if (e.present)
                        hits++;
                    if (e.full)
                        refusals++;
                    if (key_was_present !== e.present)
                    begin
                        $error("key_was_present: expected %0d actual %0d",
                               e.present, key_was_present);
                        errors++;
                    end
                    if (read_value !== e.rval)
                    begin
                        $error("read_value: expected %h actual %h", e.rval, read_value);
                        errors++;
                    end
                    if (status !== e.full)
                    begin
                        $error("status: expected %0d actual %0d", e.full, status);
                        errors++;
                    end
                    if (entry_count !== e.count)
                    begin
                        $error("entry_count: expected %0d actual %0d", e.count, entry_count);
                        errors++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 24)
                rsp_ready <= 1'b1;
            else if (stall_phase < 40)
                rsp_ready <= ($urandom_range(2) != 0);
            else
                rsp_ready <= ($urandom_range(3) == 0);
        end
    end

    // Watchdog on cycles without any accepted request or response word.
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int n;
        errors = 0;
        accepted_reqs = 0;
        checked_rsps = 0;
        hits = 0;
        refusals = 0;
        stim_done = 0;
        tbl_count = 0;
        for (int i = 0; i < CAP; i++)
        begin
            tbl_dist[i] = '0;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end

        // Directed: extremes, every request kind, absent delete, collisions.
        pending_words.push_back(make_req(REQ_LOOKUP, '0, '0, '0));
        pending_words.push_back(make_req(REQ_DELETE, '1, '0, '1));
        pending_words.push_back(make_req(REQ_INSERT, '0, '1, '0));
        pending_words.push_back(make_req(REQ_INSERT, '1, '0, '1));
        pending_words.push_back(make_req(REQ_LOOKUP, '0, '0, '0));
        pending_words.push_back(make_req(REQ_LOOKUP, '1, '1, '1));
        pending_words.push_back(make_req(REQ_INSERT, '0, 32'hA5A5_5A5A, 32'hFFFF_FC00));
        pending_words.push_back(make_req(REQ_UNUSED, '1, '1, '1));
        for (int i = 0; i < 6; i++)
            pending_words.push_back(make_req(REQ_INSERT, 32'h100 + i, 32'h5555_AAAA ^ i,
                                             32'h0000_03FF));
        pending_words.push_back(make_req(REQ_DELETE, 32'h102, '0, 32'h0000_03FF));
        pending_words.push_back(make_req(REQ_LOOKUP, 32'h105, '0, 32'h0000_03FF));
        pending_words.push_back(make_req(REQ_DELETE, 32'h999, '0, 32'h0000_03FF));
        pending_words.push_back(make_req(REQ_DELETE, '1, '0, '1));
        pending_words.push_back(make_req(REQ_LOOKUP, '1, '0, '1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Random: a spread phase, a crowded phase that exercises probe
        // overflow, then a fill phase that runs into the load limit.
        n = 0;
        while (n < 1350)
        begin
            request_t r;
            if (n < 500)
                r = random_req(0);
            else if (n < 800)
            begin
                r = random_req(1);
                if ($urandom_range(1) == 0)
                    r.kind = REQ_INSERT;
            end
            else
            begin
                r = random_req(0);
                if (n < 1200 && $urandom_range(9) < 8)
                begin
                    r.kind = REQ_INSERT;
                    r.key = $urandom();
                    r.hash = $urandom();
                end
            end
            pending_words.push_back(r);
            n++;
        end

        wait (pending_words.size() == 0);
        wait (expected_rsp.size() == 0);
        repeat (2000) @(posedge clk);

        $display("Covered %0d requests, %0d responses checked: %0d hits, %0d refused.",
                 accepted_reqs, checked_rsps, hits, refusals);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
